// File: src/ffa_pkg.sv
// shared constants, codes and control types of the first-fit allocator
`default_nettype none
package ffa_pkg;

  // address space and field widths
  localparam int MEM_WORDS        = 1024;
  localparam int ADDR_W           = 10;
  localparam int SIZE_W           = 11;
  localparam int STAT_W           = 2;
  localparam int MAX_SEGMENTS_DEF = 16;

  // stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // request kinds
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHL_RD,
    S_SHL_WR,
    S_SHR_RD,
    S_SHR_WR,
    S_FIN
  } state_t;

  // table read address select
  typedef enum logic [1:0] {
    RD_IDX,
    RD_UP,
    RD_DN
  } rd_sel_t;

  // table write select, also picks the write address
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INIT,
    WR_SHIFT,
    WR_SHRINK,
    WR_JOIN_BOTH,
    WR_JOIN_PREV,
    WR_JOIN_NEXT,
    WR_NEW
  } wr_sel_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_CLR,
    IDX_INC,
    IDX_DEC,
    IDX_COUNT
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INIT,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_NOFIT,
    RES_FULL,
    RES_HIT
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    wr_sel_t  wr_sel;
    idx_op_t  idx_op;
    cnt_op_t  cnt_op;
    logic     cap_prev;
    logic     cap_next;
    logic     save_pos;
    res_sel_t res_sel;
    logic     load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_free;
    logic size_zero;
    logic free_skip;
    logic idx_lt_count;
    logic fit;
    logic exact;
    logic below;
    logic shl_more;
    logic shr_more;
    logic overlap;
    logic join_prev;
    logic join_next;
    logic full;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: src/ffa_datapath.sv
// segment table, request registers, comparators and result register
`default_nettype none
module ffa_datapath #(
  parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ffa_pkg::cmd_t                  cmd,
  output ffa_pkg::sts_t                       sts,
  input  wire logic [ffa_pkg::IN_DATA_W-1:0]  s_tdata,
  input  wire logic [0:0]                     s_tuser,
  input  wire logic                           m_tready,
  output logic                                m_tvalid,
  output logic [ffa_pkg::OUT_DATA_W-1:0]      m_tdata
);

  localparam int AW = ffa_pkg::ADDR_W;
  localparam int SW = ffa_pkg::SIZE_W;
  localparam int LW = SW + 1;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * AW;
  localparam logic [LW-1:0] LAST_MAX = LW'(ffa_pkg::MEM_WORDS - 1);
  localparam logic [SW-1:0] ADDR_LIM = SW'(ffa_pkg::MEM_WORDS);

  // segment table, entry is {end, start}
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata;

  // request registers
  logic          op_free;
  logic [SW-1:0] size;
  logic [AW-1:0] addr;
  logic [AW-1:0] last;

  // walk state
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] count;
  logic [AW-1:0] prev_start;
  logic [AW-1:0] prev_end;
  logic [AW-1:0] next_start;
  logic [AW-1:0] next_end;

  // result and output registers
  logic [ffa_pkg::STAT_W-1:0] res_status;
  logic [AW-1:0]              res_addr;
  logic [ffa_pkg::STAT_W-1:0] out_status;
  logic [AW-1:0]              out_addr;

  logic [SW-1:0] in_size;
  logic [AW-1:0] in_addr;
  logic [LW-1:0] in_sum;
  logic [AW-1:0] in_last;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_m1;
  logic [AW-1:0] rd_start;
  logic [AW-1:0] rd_end;
  logic [SW-1:0] len;
  logic [AW-1:0] shrink_start;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          wr_en;
  logic          has_prev;
  logic          has_next;

  // input unpacking and clipped range end
  assign in_size = s_tdata[SW-1:0];
  assign in_addr = s_tdata[SW+AW-1:SW];
  assign in_sum  = LW'(in_addr) + LW'(in_size) - LW'(1);
  assign in_last = (in_sum > LAST_MAX) ? LAST_MAX[AW-1:0] : in_sum[AW-1:0];

  assign idx_p1 = idx + CW'(1);
  assign idx_m1 = idx - CW'(1);

  assign rd_start     = rdata[AW-1:0];
  assign rd_end       = rdata[EW-1:AW];
  assign len          = SW'(rd_end) - SW'(rd_start) + SW'(1);
  assign shrink_start = rd_start + size[AW-1:0];

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_free <= s_tuser[0];
      size    <= in_size;
      addr    <= in_addr;
      last    <= in_last;
    end
  end

  // read address select
  always_comb begin
    unique case (cmd.rd_sel)
      ffa_pkg::RD_IDX: raddr = idx[IW-1:0];
      ffa_pkg::RD_UP:  raddr = idx_p1[IW-1:0];
      ffa_pkg::RD_DN:  raddr = idx_m1[IW-1:0];
      default:         raddr = idx[IW-1:0];
    endcase
  end

  // write address and data select
  always_comb begin
    wr_en = 1'b1;
    waddr = idx[IW-1:0];
    wdata = rdata;
    unique case (cmd.wr_sel)
      ffa_pkg::WR_NONE:   wr_en = 1'b0;
      ffa_pkg::WR_INIT: begin
        waddr = '0;
        wdata = {AW'(ffa_pkg::MEM_WORDS - 1), AW'(0)};
      end
      ffa_pkg::WR_SHIFT:  wdata = rdata;
      ffa_pkg::WR_SHRINK: wdata = {rd_end, shrink_start};
      ffa_pkg::WR_JOIN_BOTH: begin
        waddr = idx_m1[IW-1:0];
        wdata = {next_end, prev_start};
      end
      ffa_pkg::WR_JOIN_PREV: begin
        waddr = idx_m1[IW-1:0];
        wdata = {last, prev_start};
      end
      ffa_pkg::WR_JOIN_NEXT: wdata = {next_end, addr};
      ffa_pkg::WR_NEW:       wdata = {last, addr};
      default:               wr_en = 1'b0;
    endcase
  end

  // segment table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (cmd.idx_op)
        ffa_pkg::IDX_CLR:   idx <= '0;
        ffa_pkg::IDX_INC:   idx <= idx_p1;
        ffa_pkg::IDX_DEC:   idx <= idx_m1;
        ffa_pkg::IDX_COUNT: idx <= count;
        default:            idx <= idx;
      endcase
    end
  end

  // segment count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
    end else begin
      case (cmd.cnt_op)
        ffa_pkg::CNT_INIT: count <= CW'(1);
        ffa_pkg::CNT_INC:  count <= count + CW'(1);
        ffa_pkg::CNT_DEC:  count <= count - CW'(1);
        default:           count <= count;
      endcase
    end
  end

  // neighbor capture during the free scan, and the saved insert position
  always_ff @(posedge clk) begin
    if (cmd.cap_prev) begin
      prev_start <= rd_start;
      prev_end   <= rd_end;
    end
    if (cmd.cap_next) begin
      next_start <= rd_start;
      next_end   <= rd_end;
    end
    if (cmd.save_pos) begin
      pos <= idx;
    end
  end

  // result of the current request
  always_ff @(posedge clk) begin
    case (cmd.res_sel)
      ffa_pkg::RES_OK: begin
        res_status <= ffa_pkg::ST_OK;
        res_addr   <= '0;
      end
      ffa_pkg::RES_NOFIT: begin
        res_status <= ffa_pkg::ST_NOFIT;
        res_addr   <= '0;
      end
      ffa_pkg::RES_FULL: begin
        res_status <= ffa_pkg::ST_FULL;
        res_addr   <= '0;
      end
      ffa_pkg::RES_HIT: begin
        res_status <= ffa_pkg::ST_OK;
        res_addr   <= rd_start;
      end
      default: begin
        res_status <= res_status;
        res_addr   <= res_addr;
      end
    endcase
  end

  // output register, lets the next request in while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_addr   <= res_addr;
    end
  end

  assign m_tdata = {(ffa_pkg::OUT_DATA_W - ffa_pkg::STAT_W - AW)'(0), out_addr, out_status};

  // status flags
  assign has_prev = (idx != '0);
  assign has_next = (idx < count);

  always_comb begin
    sts.op_free      = op_free;
    sts.size_zero    = (size == '0);
    sts.free_skip    = (size == '0) || (SW'(addr) >= ADDR_LIM);
    sts.idx_lt_count = has_next;
    sts.fit          = (len >= size);
    sts.exact        = (len == size);
    sts.below        = (rd_start < addr);
    sts.shl_more     = (idx_p1 < count);
    sts.shr_more     = (idx > pos);
    sts.overlap      = (has_prev && (prev_end >= addr)) ||
                       (has_next && (next_start <= last));
    sts.join_prev    = has_prev && ((SW'(prev_end) + SW'(1)) == SW'(addr));
    sts.join_next    = has_next && ((SW'(last) + SW'(1)) == SW'(next_start));
    sts.full         = (count >= CW'(MAX_SEGMENTS));
    sts.out_busy     = m_tvalid && !m_tready;
  end

endmodule
`default_nettype wire

// File: src/ffa_ctrl.sv
// request sequencer: scan, merge, insert and remove steps over the table
`default_nettype none
module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t      cmd
);

  ffa_pkg::state_t state;
  ffa_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffa_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.rd_en    = 1'b0;
    cmd.rd_sel   = ffa_pkg::RD_IDX;
    cmd.wr_sel   = ffa_pkg::WR_NONE;
    cmd.idx_op   = ffa_pkg::IDX_HOLD;
    cmd.cnt_op   = ffa_pkg::CNT_HOLD;
    cmd.cap_prev = 1'b0;
    cmd.cap_next = 1'b0;
    cmd.save_pos = 1'b0;
    cmd.res_sel  = ffa_pkg::RES_NONE;
    cmd.load_out = 1'b0;
    unique case (state)
      // write the single full-space segment
      ffa_pkg::S_INIT: begin
        cmd.wr_sel = ffa_pkg::WR_INIT;
        cmd.cnt_op = ffa_pkg::CNT_INIT;
        state_next = ffa_pkg::S_IDLE;
      end
      ffa_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          cmd.idx_op  = ffa_pkg::IDX_CLR;
          state_next  = ffa_pkg::S_START;
        end
      end
      // early outs on degenerate requests
      ffa_pkg::S_START: begin
        if (!sts.op_free && sts.size_zero) begin
          cmd.res_sel = ffa_pkg::RES_NOFIT;
          state_next  = ffa_pkg::S_FIN;
        end else if (sts.op_free && sts.free_skip) begin
          cmd.res_sel = ffa_pkg::RES_OK;
          state_next  = ffa_pkg::S_FIN;
        end else begin
          state_next = ffa_pkg::S_SCAN_RD;
        end
      end
      ffa_pkg::S_SCAN_RD: begin
        if (sts.idx_lt_count) begin
          cmd.rd_en  = 1'b1;
          state_next = ffa_pkg::S_SCAN_CHK;
        end else if (sts.op_free) begin
          state_next = ffa_pkg::S_DECIDE;
        end else begin
          cmd.res_sel = ffa_pkg::RES_NOFIT;
          state_next  = ffa_pkg::S_FIN;
        end
      end
      ffa_pkg::S_SCAN_CHK: begin
        if (sts.op_free) begin
          // find first segment not below the freed range
          if (sts.below) begin
            cmd.cap_prev = 1'b1;
            cmd.idx_op   = ffa_pkg::IDX_INC;
            state_next   = ffa_pkg::S_SCAN_RD;
          end else begin
            cmd.cap_next = 1'b1;
            state_next   = ffa_pkg::S_DECIDE;
          end
        end else if (sts.fit) begin
          cmd.res_sel = ffa_pkg::RES_HIT;
          if (sts.exact) begin
            state_next = ffa_pkg::S_SHL_RD;
          end else begin
            cmd.wr_sel = ffa_pkg::WR_SHRINK;
            state_next = ffa_pkg::S_FIN;
          end
        end else begin
          cmd.idx_op = ffa_pkg::IDX_INC;
          state_next = ffa_pkg::S_SCAN_RD;
        end
      end
      // merge, insert or reject the freed range
      ffa_pkg::S_DECIDE: begin
        cmd.res_sel = ffa_pkg::RES_OK;
        if (sts.overlap) begin
          state_next = ffa_pkg::S_FIN;
        end else if (sts.join_prev && sts.join_next) begin
          cmd.wr_sel = ffa_pkg::WR_JOIN_BOTH;
          state_next = ffa_pkg::S_SHL_RD;
        end else if (sts.join_prev) begin
          cmd.wr_sel = ffa_pkg::WR_JOIN_PREV;
          state_next = ffa_pkg::S_FIN;
        end else if (sts.join_next) begin
          cmd.wr_sel = ffa_pkg::WR_JOIN_NEXT;
          state_next = ffa_pkg::S_FIN;
        end else if (sts.full) begin
          cmd.res_sel = ffa_pkg::RES_FULL;
          state_next  = ffa_pkg::S_FIN;
        end else begin
          cmd.save_pos = 1'b1;
          cmd.idx_op   = ffa_pkg::IDX_COUNT;
          state_next   = ffa_pkg::S_SHR_RD;
        end
      end
      // remove entry idx by moving the tail down one place
      ffa_pkg::S_SHL_RD: begin
        if (sts.shl_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffa_pkg::RD_UP;
          state_next = ffa_pkg::S_SHL_WR;
        end else begin
          cmd.cnt_op = ffa_pkg::CNT_DEC;
          state_next = ffa_pkg::S_FIN;
        end
      end
      ffa_pkg::S_SHL_WR: begin
        cmd.wr_sel = ffa_pkg::WR_SHIFT;
        cmd.idx_op = ffa_pkg::IDX_INC;
        state_next = ffa_pkg::S_SHL_RD;
      end
      // open a gap at pos by moving the tail up one place
      ffa_pkg::S_SHR_RD: begin
        if (sts.shr_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffa_pkg::RD_DN;
          state_next = ffa_pkg::S_SHR_WR;
        end else begin
          cmd.wr_sel = ffa_pkg::WR_NEW;
          cmd.cnt_op = ffa_pkg::CNT_INC;
          state_next = ffa_pkg::S_FIN;
        end
      end
      ffa_pkg::S_SHR_WR: begin
        cmd.wr_sel = ffa_pkg::WR_SHIFT;
        cmd.idx_op = ffa_pkg::IDX_DEC;
        state_next = ffa_pkg::S_SHR_RD;
      end
      // hand the result to the output register
      ffa_pkg::S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/first_fit_free_list_allocator.sv
// top level of the first-fit free-segment allocator
// Keeps an address-ordered table of free segments over a 1024-unit space and
// answers one allocate or free request at a time, one result per request.
// After reset the block writes the initial full-space segment before it is
// ready. Every table step goes through the table with a registered read.
// A zero-size allocate or an ignored free ends without a table read. An
// allocate reads entries in order until one fits, then shrinks that segment,
// or on an exact fit removes it by moving the entries behind it down; a miss
// reads every segment. A free that is not skipped reads up to the first
// segment not below the range, then merges it with its neighbors or opens a
// new entry; merging with both neighbors or opening a new entry moves the
// entries behind it. The result is valid in the cycle after the request
// ends. A finished result sits in the output register, so the next request
// is taken while the previous result waits to be transferred.
`default_nettype none
module first_fit_free_list_allocator #(
  parameter int MAX_SEGMENTS = ffa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // size [10:0], addr [20:11], zero [23:21]
  input  wire logic [ffa_pkg::IN_DATA_W-1:0] s_tdata,
  // op [0]: 0 allocate, 1 free
  input  wire logic [0:0]                    s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status [1:0], addr_out [11:2], zero [15:12]
  output logic [ffa_pkg::OUT_DATA_W-1:0]     m_tdata
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  // sequencer
  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and arithmetic
  ffa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// File: src/ffa_checker.sv
// port-level checks of the allocator, bound to the top level
`default_nettype none
module ffa_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [ffa_pkg::IN_DATA_W-1:0]  s_tdata,
  input wire logic [0:0]                     s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [ffa_pkg::OUT_DATA_W-1:0] m_tdata
);

  // one request in flight: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted in back-to-back cycles");

  // status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == ffa_pkg::ST_OK ||
                  m_tdata[1:0] == ffa_pkg::ST_NOFIT ||
                  m_tdata[1:0] == ffa_pkg::ST_FULL))
    else $error("undefined status code");

  // failed results carry a zero address
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != ffa_pkg::ST_OK) |-> (m_tdata[11:2] == '0))
    else $error("nonzero address on a failed result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking stream testbench for the first-fit free-segment allocator
module testbench;

  localparam int MAX_SEG      = ffa_pkg::MAX_SEGMENTS_DEF;
  localparam int MEM_WORDS    = ffa_pkg::MEM_WORDS;
  localparam int ADDR_W       = ffa_pkg::ADDR_W;
  localparam int SIZE_W       = ffa_pkg::SIZE_W;
  localparam int STAT_W       = ffa_pkg::STAT_W;
  localparam int IN_DATA_W    = ffa_pkg::IN_DATA_W;
  localparam int OUT_DATA_W   = ffa_pkg::OUT_DATA_W;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr_out;
  } alloc_result_t;

  // a block currently held by the traffic generator
  typedef struct {
    int unsigned base;
    int unsigned len;
  } block_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // size [10:0], addr [20:11], zero [23:21]
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  // op [0]: 0 allocate, 1 free
  logic [0:0]            s_tuser  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // status [1:0], addr_out [11:2], zero [15:12]
  logic [OUT_DATA_W-1:0] m_tdata;

  // predicted free-segment table
  int unsigned free_lo [MAX_SEG];
  int unsigned free_hi [MAX_SEG];
  int unsigned free_cnt;

  alloc_result_t pending_results [$];
  block_t        live_blocks [$];
  alloc_result_t want_res;
  int            fail_count  = 0;
  int            cycle_count = 0;
  int            burst_left  = 0;
  int            stall_mode  = 0;
  int            mode_left   = 0;

  first_fit_free_list_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // remove one entry and close the hole
  task automatic drop_segment(input int unsigned idx);
    int unsigned k;
    for (k = idx; k + 1 < free_cnt; k++) begin
      free_lo[k] = free_lo[k + 1];
      free_hi[k] = free_hi[k + 1];
    end
    free_cnt--;
  endtask

  // update the predicted table for one request and give its result
  task automatic predict_request(input logic op, input int unsigned size,
                                 input int unsigned base, output alloc_result_t res,
                                 output bit took);
    int unsigned i, len, last, pos, k;
    bit hit, has_prev, has_next, overlap, join_prev, join_next;
    res.status   = ffa_pkg::ST_OK;
    res.addr_out = '0;
    took         = 1'b0;
    if (op == ffa_pkg::OP_ALLOC) begin
      // first fit, lowest address wins
      took       = 1'b1;
      res.status = ffa_pkg::ST_NOFIT;
      hit        = 1'b0;
      for (i = 0; i < free_cnt && !hit && size != 0; i++) begin
        len = free_hi[i] - free_lo[i] + 1;
        if (len >= size) begin
          hit          = 1'b1;
          res.status   = ffa_pkg::ST_OK;
          res.addr_out = ADDR_W'(free_lo[i]);
          if (len == size) drop_segment(i);
          else free_lo[i] += size;
        end
      end
    end else if (size != 0 && base < MEM_WORDS) begin
      last = base + size - 1;
      if (last >= MEM_WORDS) last = MEM_WORDS - 1;
      pos = 0;
      while (pos < free_cnt && free_lo[pos] < base) pos++;
      has_prev = pos > 0;
      has_next = pos < free_cnt;
      overlap  = 1'b0;
      join_prev = 1'b0;
      join_next = 1'b0;
      if (has_prev) begin
        overlap   = free_hi[pos - 1] >= base;
        join_prev = free_hi[pos - 1] + 1 == base;
      end
      if (has_next) begin
        overlap   = overlap || free_lo[pos] <= last;
        join_next = last + 1 == free_lo[pos];
      end
      // overlapping frees leave the table alone
      if (!overlap) begin
        took = 1'b1;
        if (join_prev && join_next) begin
          free_hi[pos - 1] = free_hi[pos];
          drop_segment(pos);
        end else if (join_prev) begin
          free_hi[pos - 1] = last;
        end else if (join_next) begin
          free_lo[pos] = base;
        end else if (free_cnt >= MAX_SEG) begin
          res.status = ffa_pkg::ST_FULL;
        end else begin
          for (k = free_cnt; k > pos; k--) begin
            free_lo[k] = free_lo[k - 1];
            free_hi[k] = free_hi[k - 1];
          end
          free_lo[pos] = base;
          free_hi[pos] = last;
          free_cnt++;
        end
      end
    end
  endtask

  // one request transfer, then maybe end the burst with a gap
  task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] base, output alloc_result_t res,
                              output bit took);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, base, size};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predict_request(op, 32'(size), 32'(base), res, took);
    pending_results.push_back(res);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // zero size, oversize, exact fit of the whole space, empty table
  task automatic test_alloc_limits();
    alloc_result_t res;
    bit took;
    send_request(ffa_pkg::OP_ALLOC, 11'd0, 10'd0, res, took);
    send_request(ffa_pkg::OP_ALLOC, 11'd2047, 10'd1023, res, took);
    send_request(ffa_pkg::OP_ALLOC, 11'd1024, 10'd0, res, took);
    send_request(ffa_pkg::OP_ALLOC, 11'd1, 10'd0, res, took);
  endtask

  // zero size, clipping at the top, double free, overlap with the next segment, merge with it
  task automatic test_free_limits();
    alloc_result_t res;
    bit took;
    send_request(ffa_pkg::OP_FREE, 11'd0, 10'd7, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd2047, 10'd1020, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd1, 10'd1020, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd8, 10'd1016, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd4, 10'd1016, res, took);
  endtask

  // fill the table, overflow it, overlap the previous segment, merge both ways
  task automatic test_table_full();
    alloc_result_t res;
    bit took;
    int unsigned k;
    for (k = 0; k < 15; k++) begin
      send_request(ffa_pkg::OP_FREE, 11'd1, ADDR_W'(2 * k), res, took);
    end
    send_request(ffa_pkg::OP_FREE, 11'd1, 10'd40, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd1, 10'd1018, res, took);
    send_request(ffa_pkg::OP_FREE, 11'd1, 10'd1, res, took);
    // hand the still allocated ranges to the random traffic
    for (k = 1; k <= 13; k++) live_blocks.push_back('{2 * k + 1, 1});
    live_blocks.push_back('{29, 987});
  endtask

  // mostly alloc and free of held blocks, some raw noise
  task automatic test_random_traffic();
    alloc_result_t res;
    bit took, front;
    logic op;
    int unsigned effective, sz, pick, cut, base, roll;
    block_t b;
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        op = 1'($urandom_range(0, 1));
        sz = $urandom_range(0, 2047);
        send_request(op, SIZE_W'(sz), ADDR_W'($urandom_range(0, 1023)), res, took);
        if (op == ffa_pkg::OP_ALLOC && res.status == ffa_pkg::ST_OK && sz != 0)
          live_blocks.push_back('{32'(res.addr_out), sz});
      end else if (roll < 55 || live_blocks.size() == 0) begin
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 1024) : $urandom_range(1, 48);
        send_request(ffa_pkg::OP_ALLOC, SIZE_W'(sz), ADDR_W'($urandom_range(0, 1023)),
                     res, took);
        if (res.status == ffa_pkg::ST_OK) live_blocks.push_back('{32'(res.addr_out), sz});
      end else begin
        pick  = $urandom_range(0, live_blocks.size() - 1);
        b     = live_blocks[pick];
        cut   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, b.len) : b.len;
        front = 1'($urandom_range(0, 1));
        base  = front ? b.base : b.base + b.len - cut;
        send_request(ffa_pkg::OP_FREE, SIZE_W'(cut), ADDR_W'(base), res, took);
        if (res.status == ffa_pkg::ST_OK) begin
          if (cut == b.len) live_blocks.delete(pick);
          else if (front) live_blocks[pick] = '{b.base + cut, b.len - cut};
          else live_blocks[pick].len = b.len - cut;
        end
      end
      if (took) effective++;
    end
  endtask

  // receiver stall pattern, switching between modes
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_tready <= ($urandom_range(0, 7) == 0);
      end
      default: begin
        m_tready <= (cycle_count % 5 != 0);
      end
    endcase
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0d addr_out %0d",
                 $time, m_tdata[1:0], m_tdata[11:2]);
      end else begin
        want_res = pending_results.pop_front();
        if (m_tdata[1:0] != want_res.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want_res.status, m_tdata[1:0]);
        end
        if (m_tdata[11:2] != want_res.addr_out) begin
          fail_count++;
          $display("%0t: addr_out mismatch, expected %0d, actual %0d",
                   $time, want_res.addr_out, m_tdata[11:2]);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reset, tests in turn, drain
  initial begin
    for (int i = 0; i < MAX_SEG; i++) begin
      free_lo[i] = 0;
      free_hi[i] = 0;
    end
    free_hi[0] = MEM_WORDS - 1;
    free_cnt   = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_alloc_limits();
    test_free_limits();
    test_table_full();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
